// ===== src/lest_pkg.sv =====
package lest_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_ON        = 3'd0;
  localparam logic [2:0] OP_OFF       = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_RANDOMIZE = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // status codes of a result item
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BOUNDS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // action codes of a result item
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  // day rule codes
  localparam logic [3:0] DAY_EVERY   = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY = 4'd8;
  localparam logic [3:0] DAY_WEEKEND = 4'd9;
  localparam logic [2:0] DAY_SUNDAY  = 3'd0;
  localparam logic [2:0] DAY_MONDAY  = 3'd1;
  localparam logic [2:0] DAY_FRIDAY  = 3'd5;
  localparam logic [2:0] DAY_SATURDAY = 3'd6;

  // width of the due-minute sum: 11-bit minute plus signed 8-bit offset
  localparam int unsigned DueW = 13;

  // work class decided by the front end
  typedef enum logic [2:0] {
    K_ON,
    K_OFF,
    K_REMOVE,
    K_RANDOMIZE,
    K_TICK,
    K_REPLY
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  status;
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
    logic [7:0]  offset;
    logic [2:0]  today;
    logic [10:0] now;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
    logic        turns_off;
    logic [7:0]  offset;
  } entry_t;

  // day rule check of a stored day code against today
  function automatic logic day_accepts(logic [3:0] code, logic [2:0] today);
    logic hit;
    hit = 1'b0;
    if (code == DAY_EVERY) hit = 1'b1;
    if (code == {1'b0, today}) hit = 1'b1;
    if (code == DAY_WEEKEND && (today == DAY_SATURDAY || today == DAY_SUNDAY)) hit = 1'b1;
    if (code == DAY_WEEKDAY && today >= DAY_MONDAY && today <= DAY_FRIDAY) hit = 1'b1;
    return hit;
  endfunction

endpackage

// ===== src/light_event_schedule_table.sv =====
// channel   direction  handshake                 fields
// in        input      in_valid_i / in_stall_o   operation, light_id, day_code, minute,
//                                                random_offset, current_day, current_minute
// out       output     out_valid_o / out_stall_i status, fired_light, action, last
//
// Scans read one entry per cycle while no output stall holds a tick scan; a schedule
// that finds a free entry ends its scan early, and an item that needs no scan
// (rejected light id, unused operation code) goes straight to its final result.
// Reset clears the valid bit of every entry at once; no clearing pass is run.
// A two-item queue lets the input side keep taking items while a scan runs.
// An output stall holds a tick scan only when a further match must pass the pending one.
module light_event_schedule_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned LIGHT_COUNT   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        light_id_i,
  input  logic [3:0]        day_code_i,
  input  logic [10:0]       minute_i,
  input  logic signed [7:0] random_offset_i,
  input  logic [2:0]        current_day_i,
  input  logic [10:0]       current_minute_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        fired_light_o,
  output logic [1:0]        action_o,
  output logic              last_o
);
  import lest_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_wr_cmd;
  logic q_vld;
  logic q_pop;
  cmd_t q_rd_cmd;

  // item decode
  lest_front #(
    .LIGHT_COUNT(LIGHT_COUNT)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .light_id_i      (light_id_i),
    .day_code_i      (day_code_i),
    .minute_i        (minute_i),
    .random_offset_i (random_offset_i),
    .current_day_i   (current_day_i),
    .current_minute_i(current_minute_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_wr_cmd)
  );

  // command queue
  lest_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_wr_cmd),
    .full_o(q_full),
    .vld_o (q_vld),
    .pop_i (q_pop),
    .data_o(q_rd_cmd)
  );

  // table scan and results
  lest_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_vld_i      (q_vld),
    .q_cmd_i      (q_rd_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .fired_light_o(fired_light_o),
    .action_o     (action_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/lest_front.sv =====
module lest_front #(
  parameter int unsigned LIGHT_COUNT = 32
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        light_id_i,
  input  logic [3:0]        day_code_i,
  input  logic [10:0]       minute_i,
  input  logic signed [7:0] random_offset_i,
  input  logic [2:0]        current_day_i,
  input  logic [10:0]       current_minute_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output lest_pkg::cmd_t    q_cmd_o
);
  import lest_pkg::*;

  logic bad_light;

  // schedule items with light ids at or above the light count are rejected up front
  assign bad_light = {1'b0, light_id_i} >= 9'(LIGHT_COUNT);

  // handshake toward the queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // classify the item
  always_comb begin
    q_cmd_o        = '0;
    q_cmd_o.light  = light_id_i;
    q_cmd_o.day    = day_code_i;
    q_cmd_o.minute = minute_i;
    q_cmd_o.offset = random_offset_i;
    q_cmd_o.today  = current_day_i;
    q_cmd_o.now    = current_minute_i;
    q_cmd_o.status = STAT_OK;
    unique case (operation_i)
      OP_ON, OP_OFF: begin
        if (bad_light) begin
          q_cmd_o.kind   = K_REPLY;
          q_cmd_o.status = STAT_BOUNDS;
        end else begin
          q_cmd_o.kind = (operation_i == OP_OFF) ? K_OFF : K_ON;
        end
      end
      OP_REMOVE:    q_cmd_o.kind = K_REMOVE;
      OP_RANDOMIZE: q_cmd_o.kind = K_RANDOMIZE;
      OP_TICK:      q_cmd_o.kind = K_TICK;
      default:      q_cmd_o.kind = K_REPLY;
    endcase
  end

endmodule

// ===== src/lest_queue.sv =====
module lest_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lest_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           vld_o,
  input  logic           pop_i,
  output lest_pkg::cmd_t data_o
);
  import lest_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o = count_q == 2'd2;
  assign vld_o  = count_q != 2'd0;
  assign data_o = slot_q[rd_ptr_q];

  // two-slot command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        slot_q[wr_ptr_q] <= data_i;
        wr_ptr_q         <= !wr_ptr_q;
      end
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ===== src/lest_back.sv =====
module lest_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_vld_i,
  input  lest_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [7:0]     fired_light_o,
  output logic [1:0]     action_o,
  output logic           last_o
);
  import lest_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                   state_q;
  cmd_t                     cmd_q;
  logic [IdxW-1:0]          iss_idx_q;
  logic                     iss_act_q;
  logic [IdxW-1:0]          ev_idx_q;
  logic                     ev_vld_q;
  entry_t                   rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     found_q;
  logic                     pend_vld_q;
  logic [7:0]               pend_light_q;
  logic [1:0]               pend_act_q;
  logic                     out_vld_q;
  logic [1:0]               out_status_q;
  logic [7:0]               out_light_q;
  logic [1:0]               out_action_q;
  logic                     out_last_q;

  entry_t                   mem [TABLE_ENTRIES];

  logic                     out_free;
  logic                     ent_valid;
  logic                     key_hit;
  logic [DueW-1:0]          due;
  logic                     tick_hit;
  logic                     is_sched;
  logic                     free_hit;
  logic                     rand_hit;
  logic                     rem_hit;
  logic                     ev_tick;
  logic                     hold;
  logic                     adv;
  logic                     mem_we;
  entry_t                   mem_wdata;

  // output register frees when empty or taken this cycle
  assign out_free = !out_vld_q || !out_stall_i;

  // entry compare in the evaluate stage
  assign ent_valid = valid_q[ev_idx_q];
  assign key_hit   = ent_valid && rd_q.light == cmd_q.light && rd_q.day == cmd_q.day
                     && rd_q.minute == cmd_q.minute;
  assign due       = {2'b00, rd_q.minute} + {{(DueW - 8){rd_q.offset[7]}}, rd_q.offset};
  assign tick_hit  = ent_valid && day_accepts(rd_q.day, cmd_q.today)
                     && due == {2'b00, cmd_q.now};

  assign is_sched = cmd_q.kind == K_ON || cmd_q.kind == K_OFF;
  assign free_hit = ev_vld_q && is_sched && !found_q && !ent_valid;
  assign rand_hit = ev_vld_q && cmd_q.kind == K_RANDOMIZE && key_hit;
  assign rem_hit  = ev_vld_q && cmd_q.kind == K_REMOVE && key_hit;
  assign ev_tick  = ev_vld_q && cmd_q.kind == K_TICK && tick_hit;

  // a second match waits while the pending one cannot move out
  assign hold = ev_tick && pend_vld_q && !out_free;
  assign adv  = !hold;

  assign q_pop_o = state_q == ST_IDLE && q_vld_i;

  // table write data
  always_comb begin
    mem_we    = (free_hit || rand_hit) && state_q == ST_SCAN;
    mem_wdata = rd_q;
    if (free_hit) begin
      mem_wdata.light     = cmd_q.light;
      mem_wdata.day       = cmd_q.day;
      mem_wdata.minute    = cmd_q.minute;
      mem_wdata.turns_off = cmd_q.kind == K_OFF;
      mem_wdata.offset    = '0;
    end else begin
      mem_wdata.offset = cmd_q.offset;
    end
  end

  // table memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ev_idx_q] <= mem_wdata;
    if (state_q == ST_SCAN && iss_act_q && adv) rd_q <= mem[iss_idx_q];
  end

  // scan control, valid bits and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_idx_q  <= '0;
      iss_act_q  <= 1'b0;
      ev_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
      valid_q    <= '0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_vld_i) begin
            cmd_q      <= q_cmd_i;
            found_q    <= 1'b0;
            pend_vld_q <= 1'b0;
            iss_idx_q  <= '0;
            if (q_cmd_i.kind == K_REPLY) begin
              state_q <= ST_DONE;
            end else begin
              iss_act_q <= 1'b1;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (adv) begin
            ev_vld_q <= iss_act_q;
            ev_idx_q <= iss_idx_q;
            if (iss_act_q) begin
              if (iss_idx_q == LastIdx) iss_act_q <= 1'b0;
              else iss_idx_q <= iss_idx_q + IdxW'(1);
            end
            if (!iss_act_q && !ev_vld_q) state_q <= ST_DONE;
            // evaluate the entry held in the read register
            if (free_hit) begin
              valid_q[ev_idx_q] <= 1'b1;
              found_q           <= 1'b1;
              iss_act_q         <= 1'b0;
            end
            if (rem_hit) valid_q[ev_idx_q] <= 1'b0;
            if (ev_tick) begin
              if (pend_vld_q) begin
                out_vld_q    <= 1'b1;
                out_status_q <= STAT_OK;
                out_light_q  <= pend_light_q;
                out_action_q <= pend_act_q;
                out_last_q   <= 1'b0;
              end
              pend_vld_q   <= 1'b1;
              pend_light_q <= rd_q.light;
              pend_act_q   <= rd_q.turns_off ? ACT_OFF : ACT_ON;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_last_q   <= 1'b1;
            out_light_q  <= '0;
            out_action_q <= ACT_NONE;
            out_status_q <= cmd_q.status;
            if (is_sched) out_status_q <= found_q ? STAT_OK : STAT_FULL;
            if (cmd_q.kind == K_TICK && pend_vld_q) begin
              out_light_q  <= pend_light_q;
              out_action_q <= pend_act_q;
            end
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign fired_light_o = out_light_q;
  assign action_o      = out_action_q;
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  // no scan activity in the idle state
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !iss_act_q && !ev_vld_q)
    else $error("scan pipeline active while idle");

  // table writes only while scanning
  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_hit || rand_hit || rem_hit) |-> state_q == ST_SCAN)
    else $error("table written outside scan");

  // a pending match only exists for a tick
  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> cmd_q.kind == K_TICK)
    else $error("pending match outside tick");

  // once a free entry is taken no further reads are issued
  a_found_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && state_q == ST_SCAN |-> !iss_act_q)
    else $error("scan continues after free entry found");

  // a held scan keeps its evaluate stage
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold && state_q == ST_SCAN |=> ev_vld_q && $stable(ev_idx_q))
    else $error("evaluate stage moved during hold");
`endif

endmodule

// ===== verif/light_event_schedule_table_checker.sv =====
`timescale 1ns / 1ps

module light_event_schedule_table_checker #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned LIGHT_COUNT   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        light_id_i,
  input  logic [3:0]        day_code_i,
  input  logic [10:0]       minute_i,
  input  logic signed [7:0] random_offset_i,
  input  logic [2:0]        current_day_i,
  input  logic [10:0]       current_minute_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        status_i,
  input  logic [7:0]        fired_light_i,
  input  logic [1:0]        action_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o
);
  import lest_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] light;
    logic [1:0] action;
    logic       last;
  } result_t;

  // shadow copy of the event table
  logic              slot_used   [TABLE_ENTRIES];
  logic [7:0]        slot_light  [TABLE_ENTRIES];
  logic [3:0]        slot_day    [TABLE_ENTRIES];
  logic [10:0]       slot_minute [TABLE_ENTRIES];
  logic              slot_off    [TABLE_ENTRIES];
  logic signed [7:0] slot_offset [TABLE_ENTRIES];

  result_t pending_results[$];
  int      mismatches = 0;

  // does a stored day rule fire on this day
  function automatic logic rule_fires(logic [3:0] rule, logic [2:0] today);
    case (rule)
      DAY_EVERY:   return 1'b1;
      DAY_WEEKDAY: return today >= DAY_MONDAY && today <= DAY_FRIDAY;
      DAY_WEEKEND: return today == DAY_SATURDAY || today == DAY_SUNDAY;
      default:     return rule == {1'b0, today};
    endcase
  endfunction

  function automatic result_t plain_reply(logic [1:0] status);
    result_t r;
    r.status = status;
    r.light  = 8'd0;
    r.action = ACT_NONE;
    r.last   = 1'b1;
    return r;
  endfunction

  // update the shadow table for one item and queue the results it causes
  task automatic schedule_table_step(input logic [2:0] op, input logic [7:0] light,
                                     input logic [3:0] day, input logic [10:0] minute,
                                     input logic signed [7:0] offset,
                                     input logic [2:0] today, input logic [10:0] now);
    int      free_slot;
    int      due_minute;
    logic    have_held;
    result_t held;
    free_slot = -1;
    have_held = 1'b0;
    held      = plain_reply(STAT_OK);
    case (op)
      OP_ON, OP_OFF: begin
        if (light >= LIGHT_COUNT) begin
          pending_results.push_back(plain_reply(STAT_BOUNDS));
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            pending_results.push_back(plain_reply(STAT_FULL));
          end else begin
            slot_used[free_slot]   = 1'b1;
            slot_light[free_slot]  = light;
            slot_day[free_slot]    = day;
            slot_minute[free_slot] = minute;
            slot_off[free_slot]    = (op == OP_OFF);
            slot_offset[free_slot] = 8'sd0;
            pending_results.push_back(plain_reply(STAT_OK));
          end
        end
      end
      OP_REMOVE, OP_RANDOMIZE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_used[i] && slot_light[i] == light && slot_day[i] == day &&
              slot_minute[i] == minute) begin
            if (op == OP_REMOVE) slot_used[i] = 1'b0;
            else slot_offset[i] = offset;
          end
        end
        pending_results.push_back(plain_reply(STAT_OK));
      end
      OP_TICK: begin
        // matches go out in table order, the final one carries last
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_used[i] && rule_fires(slot_day[i], today)) begin
            due_minute = int'(slot_minute[i]) + int'(slot_offset[i]);
            if (due_minute == int'(now)) begin
              if (have_held) pending_results.push_back(held);
              held.status = STAT_OK;
              held.light  = slot_light[i];
              held.action = slot_off[i] ? ACT_OFF : ACT_ON;
              held.last   = 1'b0;
              have_held   = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          pending_results.push_back(held);
        end else begin
          pending_results.push_back(plain_reply(STAT_OK));
        end
      end
      default: pending_results.push_back(plain_reply(STAT_OK));
    endcase
  endtask

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d light %0d action %0d last %0d, got status %0d light %0d action %0d last %0d",
               $realtime, what, want.status, want.light, want.action, want.last,
               got.status, got.light, got.action, got.last);
    end
  endfunction

  // watch both channels; results are checked before the new item is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got_result;
    result_t want_result;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_result.status = status_i;
        got_result.light  = fired_light_i;
        got_result.action = action_i;
        got_result.last   = last_i;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", plain_reply(STAT_OK), got_result);
        end else begin
          want_result = pending_results.pop_front();
          if (got_result.status !== want_result.status ||
              got_result.light !== want_result.light ||
              got_result.action !== want_result.action ||
              got_result.last !== want_result.last) begin
            note_mismatch("result mismatch", want_result, got_result);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_table_step(operation_i, light_id_i, day_code_i, minute_i, random_offset_i,
                            current_day_i, current_minute_i);
      end
    end
    pending_o    = pending_results.size();
    fail_count_o = mismatches;
  end

endmodule

// ===== verif/light_event_schedule_table_test.sv =====
`timescale 1ns / 1ps

module light_event_schedule_table_test;
  import lest_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned LIGHT_COUNT   = 32;

  // operation codes the block does not use, and day codes outside the normal rules
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;
  localparam logic [3:0] DayNever     = 4'd15;
  localparam logic [2:0] DayBeyond    = 3'd7;

  typedef struct packed {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
  } event_key_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        operation_i;
  logic [7:0]        light_id_i;
  logic [3:0]        day_code_i;
  logic [10:0]       minute_i;
  logic signed [7:0] random_offset_i;
  logic [2:0]        current_day_i;
  logic [10:0]       current_minute_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [7:0]        fired_light_o;
  logic [1:0]        action_o;
  logic              last_o;

  int fail_count;
  int pending_count;
  int send_idle_pct;
  int stall_pct;

  event_key_t recent_keys[$];

  light_event_schedule_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LIGHT_COUNT  (LIGHT_COUNT)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .light_id_i      (light_id_i),
    .day_code_i      (day_code_i),
    .minute_i        (minute_i),
    .random_offset_i (random_offset_i),
    .current_day_i   (current_day_i),
    .current_minute_i(current_minute_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .fired_light_o   (fired_light_o),
    .action_o        (action_o),
    .last_o          (last_o)
  );

  light_event_schedule_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LIGHT_COUNT  (LIGHT_COUNT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .operation_i     (operation_i),
    .light_id_i      (light_id_i),
    .day_code_i      (day_code_i),
    .minute_i        (minute_i),
    .random_offset_i (random_offset_i),
    .current_day_i   (current_day_i),
    .current_minute_i(current_minute_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .fired_light_i   (fired_light_o),
    .action_i        (action_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // random receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // hard stop
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // offsets that often line a tick up with a shifted event
  function automatic int pick_shift();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 1;
      2:       return -1;
      3:       return 30;
      4:       return -30;
      default: return int'($urandom_range(255)) - 128;
    endcase
  endfunction

  // new event key, mostly from small pools so that later items hit it
  function automatic event_key_t fresh_key();
    event_key_t k;
    k.light = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    k.day   = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    case ($urandom_range(7))
      0:       k.minute = 11'd0;
      1:       k.minute = 11'd1;
      2:       k.minute = 11'd600;
      3:       k.minute = 11'd720;
      4:       k.minute = 11'd1438;
      5:       k.minute = 11'd1439;
      default: k.minute = 11'($urandom_range(1439));
    endcase
    return k;
  endfunction

  // present one item, idling first as the phase asks, and hold it until taken
  task automatic send_item(input logic [2:0] op, input logic [7:0] light,
                           input logic [3:0] day, input logic [10:0] minute,
                           input logic signed [7:0] offset, input logic [2:0] today,
                           input logic [10:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    operation_i      <= op;
    light_id_i       <= light;
    day_code_i       <= day;
    minute_i         <= minute;
    random_offset_i  <= offset;
    current_day_i    <= today;
    current_minute_i <= now;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold off until every queued result has come out
  task automatic wait_drained();
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  // random item: schedules build up the table, the rest mostly reuse known keys
  task automatic send_random_item();
    int                pick;
    int                target;
    logic [2:0]        op;
    logic signed [7:0] offset;
    logic [2:0]        today;
    logic [10:0]       now;
    event_key_t        key;
    pick   = $urandom_range(99);
    offset = 8'($urandom_range(255));
    today  = 3'($urandom_range(7));
    now    = 11'($urandom_range(1439));
    if (recent_keys.size() != 0 && $urandom_range(2) != 0) begin
      key = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end else begin
      key = fresh_key();
    end
    if (pick < 45) begin
      op = $urandom_range(1) ? OP_OFF : OP_ON;
      if (key.light < LIGHT_COUNT) begin
        recent_keys.push_back(key);
        if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      end
    end else if (pick < 53) begin
      op = OP_REMOVE;
    end else if (pick < 63) begin
      op = OP_RANDOMIZE;
      if ($urandom_range(1)) offset = 8'(pick_shift());
    end else if (pick < 95) begin
      op = OP_TICK;
      if (key.day < 4'd7 && $urandom_range(1)) today = key.day[2:0];
      target = int'(key.minute) + pick_shift();
      if ($urandom_range(4) != 0 && target >= 0 && target <= 1439) now = 11'(target);
    end else begin
      op = 3'($urandom_range(OpSpareLast, OpSpareFirst));
    end
    send_item(op, key.light, key.day, key.minute, offset, today, now);
  endtask

  // stimulus and verdict
  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    operation_i      = OP_ON;
    light_id_i       = 8'd0;
    day_code_i       = 4'd0;
    minute_i         = 11'd0;
    random_offset_i  = 8'sd0;
    current_day_i    = 3'd0;
    current_minute_i = 11'd0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_SUNDAY, 11'd0);
    // table edges, light id bounds, weekend rule, a rule that never fires, duplicates
    send_item(OP_ON, 8'd0, DAY_EVERY, 11'd0, 8'sd0, 3'd0, 11'd0);
    send_item(OP_OFF, 8'd31, DAY_WEEKDAY, 11'd1439, -8'sd1, 3'd7, 11'd1439);
    send_item(OP_ON, 8'd32, DAY_EVERY, 11'd5, 8'sd0, 3'd0, 11'd0);
    send_item(OP_OFF, 8'd255, DayNever, 11'd1439, 8'sd127, 3'd7, 11'd1439);
    send_item(OP_ON, 8'd5, DAY_WEEKEND, 11'd600, 8'sd0, 3'd0, 11'd0);
    send_item(OP_ON, 8'd6, DayNever, 11'd600, 8'sd0, 3'd0, 11'd0);
    send_item(OP_ON, 8'd7, {1'b0, DAY_MONDAY}, 11'd100, 8'sd0, 3'd0, 11'd0);
    send_item(OP_OFF, 8'd7, {1'b0, DAY_MONDAY}, 11'd100, 8'sd0, 3'd0, 11'd0);
    // ticks: single hits, today beyond saturday, two equal events
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_SUNDAY, 11'd0);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_FRIDAY, 11'd1439);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DayBeyond, 11'd0);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_SATURDAY, 11'd600);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_MONDAY, 11'd100);
    // offsets at both extremes, pushing due minutes past the day bounds
    send_item(OP_RANDOMIZE, 8'd7, {1'b0, DAY_MONDAY}, 11'd100, -8'sd128, 3'd0, 11'd0);
    send_item(OP_RANDOMIZE, 8'd31, DAY_WEEKDAY, 11'd1439, 8'sd127, 3'd0, 11'd0);
    send_item(OP_RANDOMIZE, 8'd0, DAY_EVERY, 11'd0, 8'sd127, 3'd0, 11'd0);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_MONDAY, 11'd127);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_MONDAY, 11'd1439);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_MONDAY, 11'd100);
    // remove both equal events, then confirm nothing fires
    send_item(OP_REMOVE, 8'd7, {1'b0, DAY_MONDAY}, 11'd100, 8'sd0, 3'd0, 11'd0);
    send_item(OP_TICK, 8'd0, 4'd0, 11'd0, 8'sd0, DAY_MONDAY, 11'd28);
    // unused operation codes
    for (int k = OpSpareFirst; k <= OpSpareLast; k++) begin
      send_item(3'(k), 8'($urandom_range(255)), 4'($urandom_range(15)),
                11'($urandom_range(1439)), 8'($urandom_range(255)),
                3'($urandom_range(7)), 11'($urandom_range(1439)));
    end

    // random phases, draining the block between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      repeat (59) send_random_item();
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // final drain with no stall, then watch for stray results
    stall_pct = 0;
    wait_drained();
    repeat (4 * TABLE_ENTRIES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== light_event_schedule_table.f =====
src/lest_pkg.sv
src/lest_front.sv
src/lest_queue.sv
src/lest_back.sv
src/light_event_schedule_table.sv
verif/light_event_schedule_table_checker.sv
verif/light_event_schedule_table_test.sv
